// ----- src/lru_kv_pkg.sv -----
// Shared types for the LRU key-value cache: payload words, cell entry and
// cell control. No dependencies.
package lru_kv_pkg;

  localparam int unsigned CAP_W = 5;

  typedef struct packed {
    logic               op;      // 0 get, 1 put
    logic signed [31:0] key;
    logic        [30:0] value;
  } lru_kv_in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
  } lru_kv_out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [30:0] value;
  } lru_kv_ent_t;

  typedef struct packed {
    logic             ins;     // insert at head, drop tail beyond capacity
    logic             mov;     // move hit entry to head
    logic [CAP_W-1:0] cap_eff; // clamped capacity, 1..min(31, ENTRIES)
  } lru_kv_ctl_t;

  localparam logic        OP_GET   = 1'b0;
  localparam logic        OP_PUT   = 1'b1;
  localparam logic [31:0] MISS_VAL = 32'hFFFF_FFFF;

endpackage

// ----- src/lru_kv_cell.sv -----
// One position of the recency chain: holds an entry, compares its key,
// and shifts in its lower neighbor's entry. Depends on lru_kv_pkg.
module lru_kv_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmp_en,
  input  logic [31:0]            cmp_key,
  input  lru_kv_pkg::lru_kv_ctl_t ctl,
  input  lru_kv_pkg::lru_kv_ent_t prev_i,   // entry of the more recent neighbor
  output lru_kv_pkg::lru_kv_ent_t ent_o,
  input  logic                   hit_sfx_i,  // hit somewhere older than this cell
  output logic                   hit_sfx_o,
  input  logic [30:0]            sel_i,
  output logic [30:0]            sel_o
);
  import lru_kv_pkg::*;

  lru_kv_ent_t ent_r, ent_nxt;
  logic        hit_r, hit_nxt;
  logic        in_cap;

  assign in_cap    = IDX < 32'(ctl.cap_eff);
  assign hit_sfx_o = hit_r | hit_sfx_i;
  assign sel_o     = sel_i | (hit_r ? ent_r.value : 31'd0);
  assign ent_o     = ent_r;

  always_comb begin
    hit_nxt = cmp_en ? (ent_r.valid && (ent_r.key == cmp_key)) : hit_r;
    ent_nxt = ent_r;
    if (ctl.ins) begin
      ent_nxt       = prev_i;
      ent_nxt.valid = prev_i.valid && in_cap;
    end else if (ctl.mov && hit_sfx_o) begin
      ent_nxt = prev_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
      hit_r       <= hit_nxt;
    end
    ent_r.key   <= ent_nxt.key;
    ent_r.value <= ent_nxt.value;
  end

endmodule

// ----- src/lru_key_value_cache_unit.sv -----
// Top level of the LRU key-value cache: request FSM, capacity register,
// APB-style config port and the chain of lru_kv_cell. Depends on lru_kv_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one word per operation:
//   a get or a put with key and value. Output channel (out_valid/out_ready/
//   out_data) returns exactly one word per operation: found flag and the
//   read value (stored value or all ones on a get miss, written value on a put).
//   Entries sit in a chain ordered by recency, head is most recent. At accept
//   every cell compares its key and registers the match; then, once the output
//   register can take a word, the chain shifts by one position toward the tail
//   up to the hit (or across the whole chain on an insert) and the result is
//   registered. A new operation is not accepted until that update is done,
//   as in_ready is low in the update state.
//   A new operation is accepted while the previous result still waits; the
//   chain update stalls only while the output register is still full.
//   Reset empties the cache (all cells invalid) and sets capacity to 16.
//   Capacity (register 0, byte address 0) may only be written while idle.
module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  lru_kv_pkg::lru_kv_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output lru_kv_pkg::lru_kv_out_t out_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import lru_kv_pkg::*;

  localparam logic [CAP_W-1:0] ENT_LIM = (ENTRIES > 31) ? 5'd31 : CAP_W'(ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  lru_kv_in_t       req_r, req_nxt;
  lru_kv_out_t      out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [CAP_W-1:0] cap_eff;
  logic             accept, do_upd, any_hit;
  logic [30:0]      hit_val;
  lru_kv_ctl_t      ctl;
  lru_kv_ent_t      front;

  lru_kv_ent_t      ent_q   [ENTRIES];
  logic             sfx_q   [ENTRIES];
  logic [30:0]      sel_q   [ENTRIES];

  assign pready   = 1'b1;
  assign prdata   = {{(32-CAP_W){1'b0}}, cap_r};
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cap_eff = (cap_r == '0) ? CAP_W'(1) : ((cap_r > ENT_LIM) ? ENT_LIM : cap_r);

  assign any_hit = sfx_q[0];
  assign hit_val = sel_q[0];
  assign do_upd  = (state_r == ST_UPD) && (!out_valid_r || out_ready);

  assign ctl.ins     = do_upd && (req_r.op == OP_PUT) && !any_hit;
  assign ctl.mov     = do_upd && any_hit;
  assign ctl.cap_eff = cap_eff;

  // Head word shifted into cell 0: on a get hit it carries the old value.
  assign front.valid = 1'b1;
  assign front.key   = req_r.key;
  assign front.value = (req_r.op == OP_PUT) ? req_r.value : hit_val;

  generate
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lru_kv_ent_t prev_w;
      logic        sfx_in_w;
      logic [30:0] sel_in_w;
      if (i == 0) begin : g_head
        assign prev_w = front;
      end else begin : g_body
        assign prev_w = ent_q[i-1];
      end
      if (i == ENTRIES - 1) begin : g_tail
        assign sfx_in_w = 1'b0;
        assign sel_in_w = '0;
      end else begin : g_mid
        assign sfx_in_w = sfx_q[i+1];
        assign sel_in_w = sel_q[i+1];
      end
      lru_kv_cell #(.IDX(i)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmp_en   (accept),
        .cmp_key  (in_data.key),
        .ctl      (ctl),
        .prev_i   (prev_w),
        .ent_o    (ent_q[i]),
        .hit_sfx_i(sfx_in_w),
        .hit_sfx_o(sfx_q[i]),
        .sel_i    (sel_in_w),
        .sel_o    (sel_q[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    cap_nxt       = cap_r;

    if (psel && penable && pwrite && !paddr[2]) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt   = in_data;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (do_upd) begin
          out_nxt.found = any_hit;
          if (req_r.op == OP_PUT) begin
            out_nxt.read_value = {1'b0, req_r.value};
          end else if (any_hit) begin
            out_nxt.read_value = {1'b0, hit_val};
          end else begin
            out_nxt.read_value = MISS_VAL;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_W'(16);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cap_r       <= cap_nxt;
    end
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for lru_key_value_cache_unit: random get/put traffic with bursty
// sender and stalling receiver, checked against a recency-ordered shadow
// store. Depends on lru_kv_pkg and the cache RTL.
module tb_top;
  import lru_kv_pkg::*;

  localparam int unsigned ENTRIES = 16;
  localparam logic [2:0] ADDR_CAPACITY = 3'd0;
  localparam logic [2:0] ADDR_SPARE    = 3'd4;   // no register here, writes are dropped
  localparam int unsigned HOLD_CYCLES  = 150;

  typedef struct {
    logic [31:0] key;
    logic [30:0] value;
  } line_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  lru_kv_in_t  in_data;
  logic        out_valid;
  logic        out_ready;
  lru_kv_out_t out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lru_kv_in_t  pending_ops[$];
  lru_kv_out_t expected_results[$];
  line_t       shadow_lines[$];       // index 0 is the most recent entry
  logic [4:0]  capacity_setting;
  int          mismatch_count;

  int          burst_left;
  int          gap_left;
  rx_mode_t    rx_mode;
  int          rx_mode_left;
  int          hold_left;
  logic        hold_request;
  logic        hold_done;

  lru_kv_out_t want;

  lru_key_value_cache_unit #(.ENTRIES(ENTRIES)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow store: list ordered by recency, tail is the eviction victim.
  function automatic lru_kv_out_t cache_access(lru_kv_in_t req);
    int          hit;
    int          cap;
    line_t       ln;
    lru_kv_out_t res;
    hit = -1;
    foreach (shadow_lines[i])
      if (shadow_lines[i].key == req.key) hit = i;
    if (req.op == OP_GET) begin
      if (hit < 0) begin
        res.found      = 1'b0;
        res.read_value = MISS_VAL;
      end else begin
        ln = shadow_lines[hit];
        shadow_lines.delete(hit);
        shadow_lines.insert(0, ln);
        res.found      = 1'b1;
        res.read_value = {1'b0, ln.value};
      end
    end else begin
      if (hit >= 0) begin
        ln = shadow_lines[hit];
        shadow_lines.delete(hit);
        res.found = 1'b1;
      end else begin
        cap = capacity_setting;
        if (cap < 1) cap = 1;
        if (cap > ENTRIES) cap = ENTRIES;
        while (shadow_lines.size() >= cap) shadow_lines.delete(shadow_lines.size() - 1);
        ln.key    = req.key;
        res.found = 1'b0;
      end
      ln.value = req.value;
      shadow_lines.insert(0, ln);
      res.read_value = {1'b0, req.value};
    end
    return res;
  endfunction

  // Driver: bursts of random length, random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() != 0) begin
        in_data  <= pending_ops.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver ready: randomly chosen pattern, redrawn when its run ends, plus one long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b1;
      rx_mode      <= RX_STREAM;
      rx_mode_left <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 2));
        rx_mode_left <= $urandom_range(10, 60);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STREAM: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: predict on input accept, check on output accept.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) expected_results.push_back(cache_access(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("ERROR: result word with nothing expected: found=%0d value=%h",
                     out_data.found, out_data.read_value);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.found !== want.found || out_data.read_value !== want.read_value) begin
            if (mismatch_count < 10)
              $display("ERROR: found exp %0d got %0d, read_value exp %h got %h",
                       want.found, out_data.found, want.read_value, out_data.read_value);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_CAPACITY) capacity_setting = data[4:0];
    @(negedge clk);
  endtask

  task automatic queue_op(input logic op, input logic [31:0] key, input logic [30:0] value);
    lru_kv_in_t w;
    w.op    = op;
    w.key   = key;
    w.value = value;
    pending_ops.push_back(w);
  endtask

  // Keys come mostly from a pool a bit larger than the capacity, so hits,
  // overwrites and evictions all stay frequent.
  task automatic random_phase(input int n_ops);
    logic [31:0] key_pool[$];
    logic [31:0] k;
    logic [31:0] r;
    logic [30:0] v;
    int          pool_size;
    int          sel;
    pool_size = capacity_setting + $urandom_range(1, 6);
    for (int i = 0; i < pool_size; i++) begin
      sel = $urandom_range(0, 11);
      case (sel)
        0:       k = 32'h8000_0000;
        1:       k = 32'h7FFF_FFFF;
        2:       k = 32'h0000_0000;
        3:       k = 32'hFFFF_FFFF;
        default: k = $urandom;
      endcase
      key_pool.push_back(k);
    end
    for (int i = 0; i < n_ops; i++) begin
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      r = $urandom;
      sel = $urandom_range(0, 15);
      if (sel == 0) v = '0;
      else if (sel == 1) v = 31'h7FFF_FFFF;
      else v = r[30:0];
      queue_op($urandom_range(0, 1) ? OP_PUT : OP_GET, k, v);
    end
  endtask

  initial begin
    logic [4:0] phase_caps[13];
    phase_caps = '{5'd1, 5'd31, 5'd16, 5'd3, 5'd8, 5'd17, 5'd2,
                   5'd12, 5'd16, 5'd5, 5'd1, 5'd0, 5'd16};
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    capacity_setting = 5'd16;
    mismatch_count   = 0;
    hold_request     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty store, extreme keys and values, hits, overwrite, misses
    queue_op(OP_GET, 32'h8000_0000, 31'h0);
    queue_op(OP_PUT, 32'h8000_0000, 31'h0);
    queue_op(OP_PUT, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_op(OP_PUT, 32'h0000_0000, 31'h1);
    queue_op(OP_PUT, 32'hFFFF_FFFF, 31'h2AAA_AAAA);
    queue_op(OP_GET, 32'h7FFF_FFFF, 31'h5555_5555);
    queue_op(OP_PUT, 32'h8000_0000, 31'h5555_5555);
    queue_op(OP_GET, 32'h8000_0000, 31'h0);
    queue_op(OP_GET, 32'hFFFF_FFFF, 31'h0);
    queue_op(OP_GET, 32'h0000_0001, 31'h0);
    queue_op(OP_GET, 32'h0000_0000, 31'h0);
    wait_idle();

    // zero capacity acts as one, and shrinking below occupancy evicts on insert
    write_reg(ADDR_CAPACITY, 32'd0);
    queue_op(OP_PUT, 32'h1234_5678, 31'h3);
    queue_op(OP_GET, 32'h0000_0000, 31'h0);
    queue_op(OP_GET, 32'h1234_5678, 31'h0);
    queue_op(OP_PUT, 32'h0F0F_0F0F, 31'h4);
    queue_op(OP_GET, 32'h1234_5678, 31'h0);
    wait_idle();

    // write to an address with no register must not touch capacity
    write_reg(ADDR_SPARE, 32'd3);
    random_phase(60);
    wait_idle();

    foreach (phase_caps[p]) begin
      write_reg(ADDR_CAPACITY, {27'd0, phase_caps[p]});
      if (p == 2) hold_request = 1'b1;
      random_phase(92);
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
